/* rtl/perlin_noise_3d_octave_accumulate_core_assert.svh */
// Assertion macros shared by the checker of the octave accumulate core.
// Each macro needs signals named clock and reset in the scope where it is used.
`ifndef PERLIN_NOISE_3D_OCTAVE_ACCUMULATE_CORE_ASSERT_SVH
`define PERLIN_NOISE_3D_OCTAVE_ACCUMULATE_CORE_ASSERT_SVH

// same-cycle implication
`define PN3_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pn3oct same-cycle check failed");

// next-cycle implication
`define PN3_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pn3oct next-cycle check failed");

`endif

/* rtl/pn3oct_pkg.sv */
// Package of the 3D Perlin octave accumulate core: field widths, limits,
// function codes and the control word that travels down the pipeline.
// No dependencies.
package pn3oct_pkg;

   localparam int TABLE_COUNT_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int COORD_W = 48;
   localparam int NOISE_W = 18;
   localparam int SUM_W   = 40;

   localparam logic signed [NOISE_W-1:0] NOISE_MAX = {1'b0, {(NOISE_W-1){1'b1}}};
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = {1'b1, {(NOISE_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   typedef struct packed {
      logic                    load;   // table write, selected table exists
      logic                    eval;   // noise evaluation, selected table exists
      logic [3:0]              shift;
      logic signed [SUM_W-1:0] sum;
   } ctl_type;

endpackage

/* rtl/perlin_noise_3d_octave_accumulate_core.sv */
// Octave accumulate core for improved 3D Perlin noise in fixed point.
// Depends on pn3oct_pkg.
//
// Usage:
//  - req channel (req_valid / req_stall): one transaction per item. func=0
//    writes entry_value into entry entry_index of table table_select.
//    func=1 evaluates noise at (coord_x, coord_y, coord_z) with the selected
//    table, weights it by 2^octave_shift and adds it to sum_in.
//  - rsp channel (rsp_valid / rsp_stall): exactly one result per request, in
//    request order. Loads and unknown tables return noise 0 and sum_in.
//  - Throughput: one transaction per clock when the receiver does not stall.
//  - Pipeline: input register, three hash stages on seven table copies
//    (two read ports each), gradient, three lerp multiply/add pairs, noise
//    clamp, then the weighted add and saturation into the output register.
//    Table writes happen in each copy at the stage that reads it, so loads
//    and evaluations see the tables in request order.
//  - rsp_stall while rsp_valid is high freezes the whole pipeline;
//    req_stall rises in the same cycle. Nothing is dropped or repeated.
//  - Reset clears all valid bits. Table contents are undefined until written.
module perlin_noise_3d_octave_accumulate_core
   import pn3oct_pkg::*;
#(
   parameter int TABLE_COUNT = TABLE_COUNT_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic [3:0]                req_table_select,
   input  logic [7:0]                req_entry_index,
   input  logic [7:0]                req_entry_value,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic [3:0]                req_octave_shift,
   input  logic signed [SUM_W-1:0]   req_sum_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [NOISE_W-1:0] rsp_noise_value,
   output logic signed [SUM_W-1:0]   rsp_sum_out,
   output logic                      rsp_saturated
);

   localparam int F         = FRAC_BITS;
   localparam int SW        = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int AW        = SW + 8;
   localparam int MEM_DEPTH = (1 << SW) * 256;
   localparam int GW        = F + 2;
   localparam int LW        = F + 3;
   localparam int PW        = 2 * F + 8;
   localparam int CW        = (LW > NOISE_W) ? LW : NOISE_W;
   localparam int NCOPY     = 7;
   localparam int LAST      = 10;

   function automatic logic signed [GW-1:0] grad_f(input logic [3:0] h,
         input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
         input logic signed [GW-1:0] z);
      logic signed [GW-1:0] r;
      unique case (h)
         4'h0: r = x + y;
         4'h1: r = -x + y;
         4'h2: r = x - y;
         4'h3: r = -x - y;
         4'h4: r = x + z;
         4'h5: r = -x + z;
         4'h6: r = x - z;
         4'h7: r = -x - z;
         4'h8: r = y + z;
         4'h9: r = -y + z;
         4'hA: r = y - z;
         4'hB: r = -y - z;
         4'hC: r = y + x;
         4'hD: r = -y + z;
         4'hE: r = y - x;
         4'hF: r = -y - z;
      endcase
      return r;
   endfunction

   // t * (b - a), t unsigned below one
   function automatic logic signed [PW-1:0] lmul(input logic [F:0] t,
         input logic signed [LW-1:0] a, input logic signed [LW-1:0] b);
      logic signed [PW-1:0] d;
      d = PW'(b) - PW'(a);
      return PW'($signed({1'b0, t})) * d;
   endfunction

   // a + floor(p / 2^F)
   function automatic logic signed [LW-1:0] lsum(input logic signed [LW-1:0] a,
         input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = PW'(a) + (p >>> F);
      return LW'(s);
   endfunction

   function automatic logic signed [GW-1:0] frac_pos(input logic [F-1:0] f);
      return $signed({2'b00, f});
   endfunction

   function automatic logic signed [GW-1:0] frac_neg(input logic [F-1:0] f);
      return $signed({2'b00, f} - {2'b01, {F{1'b0}}});
   endfunction

   logic                    adv;
   logic [LAST:0]           vld_ff;
   ctl_type                 ctl_ff [LAST+1];
   logic [AW-1:0]           waddr_ff [3];
   logic [7:0]              wval_ff [3];
   logic [SW-1:0]           tsel_ff [3];
   logic [7:0]              hx_ff;
   logic [7:0]              hy_ff [2];
   logic [7:0]              hz_ff [3];
   logic [F-1:0]            fr_ff [4][3];
   logic [F-1:0]            f2_ff [3];
   logic [F-1:0]            f3_ff [3];
   logic [F+4:0]            p_ff [3];
   logic [F:0]              fd_ff [3:8][3];
   logic signed [LW-1:0]    g_ff [8];
   logic signed [PW-1:0]    pr_ff [4];
   logic signed [LW-1:0]    ga_ff [4];
   logic signed [LW-1:0]    lx_ff [4];
   logic signed [PW-1:0]    py_ff [2];
   logic signed [LW-1:0]    pa_ff [2];
   logic signed [LW-1:0]    ly_ff [2];
   logic signed [PW-1:0]    pz_ff;
   logic signed [LW-1:0]    lz_ff;
   logic signed [NOISE_W-1:0] noise_ff;
   logic                    rsp_valid_ff;
   logic signed [NOISE_W-1:0] rsp_noise_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic                    rsp_sat_ff;

   // table copies
   logic [7:0]    rd0_ff [NCOPY];
   logic [7:0]    rd1_ff [NCOPY];
   logic [AW-1:0] ra0 [NCOPY];
   logic [AW-1:0] ra1 [NCOPY];
   logic          we [NCOPY];
   logic [AW-1:0] wa [NCOPY];
   logic [7:0]    wd [NCOPY];

   logic [7:0]    hash_a, hash_b, hash_aa, hash_ab, hash_ba, hash_bb;
   logic          in_range;
   ctl_type       ctl_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;
   assign rsp_sum_out     = rsp_sum_ff;
   assign rsp_saturated   = rsp_sat_ff;

   assign in_range = int'(req_table_select) < TABLE_COUNT;

   always_comb begin
      ctl_in.load  = in_range && (req_func == FUNC_LOAD);
      ctl_in.eval  = in_range && (req_func == FUNC_EVAL);
      ctl_in.shift = req_octave_shift;
      ctl_in.sum   = req_sum_in;
   end

   // hash addresses, each copy written at the stage that reads it
   always_comb begin
      hash_a  = rd0_ff[0] + hy_ff[1];
      hash_b  = rd1_ff[0] + hy_ff[1];
      hash_aa = rd0_ff[1] + hz_ff[2];
      hash_ab = rd1_ff[1] + hz_ff[2];
      hash_ba = rd0_ff[2] + hz_ff[2];
      hash_bb = rd1_ff[2] + hz_ff[2];

      ra0[0] = {tsel_ff[0], hx_ff};
      ra1[0] = {tsel_ff[0], hx_ff + 8'd1};
      ra0[1] = {tsel_ff[1], hash_a};
      ra1[1] = {tsel_ff[1], hash_a + 8'd1};
      ra0[2] = {tsel_ff[1], hash_b};
      ra1[2] = {tsel_ff[1], hash_b + 8'd1};
      ra0[3] = {tsel_ff[2], hash_aa};
      ra1[3] = {tsel_ff[2], hash_aa + 8'd1};
      ra0[4] = {tsel_ff[2], hash_ab};
      ra1[4] = {tsel_ff[2], hash_ab + 8'd1};
      ra0[5] = {tsel_ff[2], hash_ba};
      ra1[5] = {tsel_ff[2], hash_ba + 8'd1};
      ra0[6] = {tsel_ff[2], hash_bb};
      ra1[6] = {tsel_ff[2], hash_bb + 8'd1};

      for (int c = 0; c < NCOPY; c++) begin
         if (c == 0) begin
            we[c] = vld_ff[0] && ctl_ff[0].load;
            wa[c] = waddr_ff[0];
            wd[c] = wval_ff[0];
         end else if (c < 3) begin
            we[c] = vld_ff[1] && ctl_ff[1].load;
            wa[c] = waddr_ff[1];
            wd[c] = wval_ff[1];
         end else begin
            we[c] = vld_ff[2] && ctl_ff[2].load;
            wa[c] = waddr_ff[2];
            wd[c] = wval_ff[2];
         end
      end
   end

   for (genvar c = 0; c < NCOPY; c++) begin : g_copy
      logic [7:0] mem [MEM_DEPTH];
      always_ff @(posedge clock) begin
         if (adv) begin
            if (we[c]) begin
               mem[wa[c]] <= wd[c];
            end
            rd0_ff[c] <= mem[ra0[c]];
            rd1_ff[c] <= mem[ra1[c]];
         end
      end
   end

   // fade pieces
   logic [2*F-1:0] f2_in [3];
   logic [2*F-1:0] f3_in [3];
   logic [F+5:0]   p_in [3];
   logic [2*F+4:0] u_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         f2_in[k] = (2*F)'(fr_ff[0][k]) * (2*F)'(fr_ff[0][k]);
         f3_in[k] = (2*F)'(f2_ff[k]) * (2*F)'(fr_ff[1][k]);
         p_in[k]  = (F+6)'(f2_ff[k]) * (F+6)'(6) - (F+6)'(fr_ff[1][k]) * (F+6)'(15)
                    + ((F+6)'(10) << F);
         u_in[k]  = (2*F+5)'(f3_ff[k]) * (2*F+5)'(p_ff[k]);
      end
   end

   logic signed [LW-1:0] nz;
   logic signed [CW-1:0] nzw;
   logic signed [NOISE_W-1:0] noise_in;
   logic signed [SUM_W:0] wt, acc;

   always_comb begin
      nz  = lsum(lz_ff, pz_ff);
      nzw = CW'(nz);
      if (nzw > CW'(NOISE_MAX)) begin
         noise_in = NOISE_MAX;
      end else if (nzw < CW'(NOISE_MIN)) begin
         noise_in = NOISE_MIN;
      end else begin
         noise_in = NOISE_W'(nzw);
      end
      wt  = (SUM_W+1)'(noise_ff) <<< ctl_ff[LAST].shift;
      acc = (SUM_W+1)'(ctl_ff[LAST].sum) + wt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAST-1:0], req_valid};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // input stage
         ctl_ff[0]   <= ctl_in;
         waddr_ff[0] <= {SW'(req_table_select), req_entry_index};
         wval_ff[0]  <= req_entry_value;
         tsel_ff[0]  <= SW'(req_table_select);
         hx_ff       <= req_coord_x[F+7:F];
         hy_ff[0]    <= req_coord_y[F+7:F];
         hz_ff[0]    <= req_coord_z[F+7:F];
         fr_ff[0][0] <= req_coord_x[F-1:0];
         fr_ff[0][1] <= req_coord_y[F-1:0];
         fr_ff[0][2] <= req_coord_z[F-1:0];

         for (int s = 1; s <= LAST; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         for (int s = 1; s < 3; s++) begin
            waddr_ff[s] <= waddr_ff[s-1];
            wval_ff[s]  <= wval_ff[s-1];
            tsel_ff[s]  <= tsel_ff[s-1];
            hz_ff[s]    <= hz_ff[s-1];
         end
         hy_ff[1] <= hy_ff[0];
         for (int s = 1; s < 4; s++) begin
            fr_ff[s] <= fr_ff[s-1];
         end

         for (int k = 0; k < 3; k++) begin
            f2_ff[k]    <= f2_in[k][2*F-1:F];
            f3_ff[k]    <= f3_in[k][2*F-1:F];
            p_ff[k]     <= p_in[k][F+5] ? '0 : p_in[k][F+4:0];
            fd_ff[3][k] <= u_in[k][2*F:F];
         end
         for (int s = 4; s <= 8; s++) begin
            fd_ff[s] <= fd_ff[s-1];
         end

         // gradients at the eight corners
         g_ff[0] <= LW'(grad_f(rd0_ff[3][3:0], frac_pos(fr_ff[3][0]),
                               frac_pos(fr_ff[3][1]), frac_pos(fr_ff[3][2])));
         g_ff[1] <= LW'(grad_f(rd0_ff[5][3:0], frac_neg(fr_ff[3][0]),
                               frac_pos(fr_ff[3][1]), frac_pos(fr_ff[3][2])));
         g_ff[2] <= LW'(grad_f(rd0_ff[4][3:0], frac_pos(fr_ff[3][0]),
                               frac_neg(fr_ff[3][1]), frac_pos(fr_ff[3][2])));
         g_ff[3] <= LW'(grad_f(rd0_ff[6][3:0], frac_neg(fr_ff[3][0]),
                               frac_neg(fr_ff[3][1]), frac_pos(fr_ff[3][2])));
         g_ff[4] <= LW'(grad_f(rd1_ff[3][3:0], frac_pos(fr_ff[3][0]),
                               frac_pos(fr_ff[3][1]), frac_neg(fr_ff[3][2])));
         g_ff[5] <= LW'(grad_f(rd1_ff[5][3:0], frac_neg(fr_ff[3][0]),
                               frac_pos(fr_ff[3][1]), frac_neg(fr_ff[3][2])));
         g_ff[6] <= LW'(grad_f(rd1_ff[4][3:0], frac_pos(fr_ff[3][0]),
                               frac_neg(fr_ff[3][1]), frac_neg(fr_ff[3][2])));
         g_ff[7] <= LW'(grad_f(rd1_ff[6][3:0], frac_neg(fr_ff[3][0]),
                               frac_neg(fr_ff[3][1]), frac_neg(fr_ff[3][2])));

         // lerp along x
         for (int k = 0; k < 4; k++) begin
            pr_ff[k] <= lmul(fd_ff[4][0], g_ff[2*k], g_ff[2*k+1]);
            ga_ff[k] <= g_ff[2*k];
            lx_ff[k] <= lsum(ga_ff[k], pr_ff[k]);
         end
         // lerp along y
         for (int k = 0; k < 2; k++) begin
            py_ff[k] <= lmul(fd_ff[6][1], lx_ff[2*k], lx_ff[2*k+1]);
            pa_ff[k] <= lx_ff[2*k];
            ly_ff[k] <= lsum(pa_ff[k], py_ff[k]);
         end
         // lerp along z
         pz_ff    <= lmul(fd_ff[8][2], ly_ff[0], ly_ff[1]);
         lz_ff    <= ly_ff[0];
         noise_ff <= noise_in;

         // weighted accumulate
         if (ctl_ff[LAST].eval) begin
            rsp_noise_ff <= noise_ff;
            if (acc[SUM_W] != acc[SUM_W-1]) begin
               rsp_sum_ff <= acc[SUM_W] ? SUM_MIN : SUM_MAX;
               rsp_sat_ff <= 1'b1;
            end else begin
               rsp_sum_ff <= acc[SUM_W-1:0];
               rsp_sat_ff <= 1'b0;
            end
         end else begin
            rsp_noise_ff <= '0;
            rsp_sum_ff   <= ctl_ff[LAST].sum;
            rsp_sat_ff   <= 1'b0;
         end
      end
   end

endmodule

/* rtl/pn3oct_checker.sv */
// Port-level checker of the octave accumulate core, bound to the top level.
// Depends on pn3oct_pkg and perlin_noise_3d_octave_accumulate_core_assert.svh.
`include "perlin_noise_3d_octave_accumulate_core_assert.svh"

module pn3oct_checker
   import pn3oct_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [NOISE_W-1:0] rsp_noise_value,
   input logic signed [SUM_W-1:0]   rsp_sum_out,
   input logic                      rsp_saturated
);

   // input side only backs up when a finished result is held
   `PN3_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   `PN3_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sum_out) && $stable(rsp_noise_value) && $stable(rsp_saturated))
   `PN3_ASSERT_IMP(a_sat_rail, rsp_valid && rsp_saturated, rsp_sum_out == SUM_MAX || rsp_sum_out == SUM_MIN)
   // zero noise leaves the sum untouched, so it cannot clamp
   `PN3_ASSERT_IMP(a_zero_no_sat, rsp_valid && rsp_noise_value == '0, !rsp_saturated)

endmodule

bind perlin_noise_3d_octave_accumulate_core pn3oct_checker u_pn3oct_checker (.*);

/* bench/testbench.sv */
// Self-checking bench for the 3D Perlin octave accumulate core.
// Preloads permutation tables, runs a directed table, then random traffic.
// Depends on pn3oct_pkg and perlin_noise_3d_octave_accumulate_core.
`timescale 1ns / 1ps

module testbench;
   import pn3oct_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int RAND_ITEMS = 560;
   localparam int CYCLE_MAX  = 300000;

   typedef struct {
      logic                      func;
      logic [3:0]                sel;
      logic [7:0]                idx;
      logic [7:0]                val;
      logic signed [COORD_W-1:0] x, y, z;
      logic [3:0]                shift;
      logic signed [SUM_W-1:0]   sum;
   } sample_req_type;

   typedef struct {
      logic signed [NOISE_W-1:0] noise;
      logic signed [SUM_W-1:0]   sum;
      logic                      sat;
   } octave_rsp_type;

   typedef struct {
      sample_req_type req;
      bit             typed;
      octave_rsp_type rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = 1'b0;
   logic [3:0] req_table_select = '0;
   logic [7:0] req_entry_index = '0;
   logic [7:0] req_entry_value = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic [3:0] req_octave_shift = '0;
   logic signed [SUM_W-1:0] req_sum_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [NOISE_W-1:0] rsp_noise_value;
   logic signed [SUM_W-1:0] rsp_sum_out;
   logic rsp_saturated;

   logic [7:0]     perm_copy [16][256];
   bit   [255:0]   entry_written [16];
   octave_rsp_type pending_results [$];
   int             mismatches = 0;
   int             cycles = 0;
   int             sender_idle_pct = 13;
   int             receiver_stall_pct = 65;

   perlin_noise_3d_octave_accumulate_core DUT (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < receiver_stall_pct);

   function automatic longint fade_fx(longint f);
      longint f2, f3, p;
      f2 = (f * f) >>> FRAC;
      f3 = (f2 * f) >>> FRAC;
      p = 6 * f2 - 15 * f + 10 * (longint'(1) << FRAC);
      if (p < 0) p = 0;
      return (f3 * p) >>> FRAC;
   endfunction

   function automatic longint lerp_fx(longint t, longint a, longint b);
      return a + ((t * (b - a)) >>> FRAC);   // arithmetic shift floors
   endfunction

   function automatic longint gradient(logic [7:0] h, longint x, longint y, longint z);
      case (h[3:0])
         4'h0: return x + y;
         4'h1: return -x + y;
         4'h2: return x - y;
         4'h3: return -x - y;
         4'h4: return x + z;
         4'h5: return -x + z;
         4'h6: return x - z;
         4'h7: return -x - z;
         4'h8: return y + z;
         4'h9: return -y + z;
         4'hA: return y - z;
         4'hB: return -y - z;
         4'hC: return y + x;
         4'hD: return -y + z;
         4'hE: return y - x;
         default: return -y - z;
      endcase
   endfunction

   function automatic int perm(int t, int i);
      return perm_copy[t][i & 8'hFF];
   endfunction

   // Computes one result and applies table writes, in request order.
   function automatic octave_rsp_type accumulate_octave(sample_req_type r);
      octave_rsp_type o;
      int t, cx, cy, cz, a, b, aa, ab, ba, bb;
      longint x, y, z, xm, ym, zm, u, v, w, x1, x2, xx1, xx2, n, s;
      t = r.sel;
      s = r.sum;
      n = 0;
      o.sat = 1'b0;
      if (r.func == FUNC_LOAD) begin
         perm_copy[t][r.idx] = r.val;
         entry_written[t][r.idx] = 1'b1;
      end else begin
         cx = r.x[FRAC+7:FRAC]; cy = r.y[FRAC+7:FRAC]; cz = r.z[FRAC+7:FRAC];
         x = r.x[FRAC-1:0]; y = r.y[FRAC-1:0]; z = r.z[FRAC-1:0];
         xm = x - (longint'(1) << FRAC);
         ym = y - (longint'(1) << FRAC);
         zm = z - (longint'(1) << FRAC);
         u = fade_fx(x); v = fade_fx(y); w = fade_fx(z);
         a = perm(t, cx) + cy;
         b = perm(t, cx + 1) + cy;
         aa = perm(t, a) + cz;
         ab = perm(t, a + 1) + cz;
         ba = perm(t, b) + cz;
         bb = perm(t, b + 1) + cz;
         x1 = lerp_fx(u, gradient(perm(t, aa), x, y, z), gradient(perm(t, ba), xm, y, z));
         x2 = lerp_fx(u, gradient(perm(t, ab), x, ym, z), gradient(perm(t, bb), xm, ym, z));
         xx1 = lerp_fx(u, gradient(perm(t, aa + 1), x, y, zm),
                       gradient(perm(t, ba + 1), xm, y, zm));
         xx2 = lerp_fx(u, gradient(perm(t, ab + 1), x, ym, zm),
                       gradient(perm(t, bb + 1), xm, ym, zm));
         n = lerp_fx(w, lerp_fx(v, x1, x2), lerp_fx(v, xx1, xx2));
         if (n > longint'(NOISE_MAX)) n = NOISE_MAX;
         if (n < longint'(NOISE_MIN)) n = NOISE_MIN;
         s = s + n * (longint'(1) << r.shift);
         if (s > longint'(SUM_MAX)) begin
            s = SUM_MAX;
            o.sat = 1'b1;
         end else if (s < longint'(SUM_MIN)) begin
            s = SUM_MIN;
            o.sat = 1'b1;
         end
      end
      o.noise = n[NOISE_W-1:0];
      o.sum = s[SUM_W-1:0];
      return o;
   endfunction

   // Holds the transaction until an edge with stall low, then maybe idles a cycle.
   task automatic send_item(sample_req_type r, bit typed, octave_rsp_type typed_rsp);
      octave_rsp_type predicted;
      req_valid <= 1'b1;
      req_func <= r.func;
      req_table_select <= r.sel;
      req_entry_index <= r.idx;
      req_entry_value <= r.val;
      req_coord_x <= r.x;
      req_coord_y <= r.y;
      req_coord_z <= r.z;
      req_octave_shift <= r.shift;
      req_sum_in <= r.sum;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      predicted = accumulate_octave(r);
      pending_results.push_back(typed ? typed_rsp : predicted);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic sample_req_type make_load(int t, int i, int v);
      sample_req_type r;
      r = '{default: '0};
      r.func = FUNC_LOAD; r.sel = 4'(t); r.idx = 8'(i); r.val = 8'(v);
      r.x = COORD_W'({$urandom, $urandom}); r.sum = SUM_W'({$urandom, $urandom});
      r.shift = 4'($urandom);
      return r;
   endfunction

   function automatic sample_req_type make_eval(int t, logic signed [COORD_W-1:0] x,
                                                logic signed [COORD_W-1:0] y,
                                                logic signed [COORD_W-1:0] z,
                                                int sh, logic signed [SUM_W-1:0] s);
      sample_req_type r;
      r = '{default: '0};
      r.func = FUNC_EVAL; r.sel = 4'(t); r.x = x; r.y = y; r.z = z;
      r.shift = 4'(sh); r.sum = s;
      r.idx = 8'($urandom); r.val = 8'($urandom);
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord();
      logic signed [COORD_W-1:0] c;
      c = COORD_W'({$urandom, $urandom});
      case ($urandom_range(3))
         0: c = COORD_W'($signed(c[27:0]));   // near the origin, either sign via bit 27
         1: c = COORD_W'($signed(c[23:0])) - (48'sd1 <<< 23);
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic signed [SUM_W-1:0] random_sum();
      logic signed [SUM_W-1:0] s;
      s = SUM_W'({$urandom, $urandom});
      case ($urandom_range(3))
         0: s = SUM_MAX - SUM_W'($urandom_range(1 << 20));
         1: s = SUM_MIN + SUM_W'($urandom_range(1 << 20));
         default: ;
      endcase
      return s;
   endfunction

   directed_row_type directed [$];
   int loaded_tables [4] = '{0, 5, 10, 15};

   initial begin
      directed_row_type row;
      sample_req_type r;
      octave_rsp_type none;
      int order [256];
      int j, k, tmp, t;
      none = '{default: '0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill four tables with shuffled permutations before any evaluation
      foreach (loaded_tables[n]) begin
         for (j = 0; j < 256; j++) order[j] = j;
         for (j = 255; j > 0; j--) begin
            k = $urandom_range(j);
            tmp = order[j]; order[j] = order[k]; order[k] = tmp;
         end
         for (j = 0; j < 256; j++) send_item(make_load(loaded_tables[n], j, order[j]), 0, none);
      end

      // loads echo sum_in with zero noise
      r = make_load(15, 255, 255);
      row = '{r, 1, '{18'sd0, r.sum, 1'b0}}; directed.push_back(row);
      r = make_load(0, 0, 0);
      row = '{r, 1, '{18'sd0, r.sum, 1'b0}}; directed.push_back(row);
      r = make_load(3, 128, 77); r.sum = SUM_MAX;
      row = '{r, 1, '{18'sd0, SUM_MAX, 1'b0}}; directed.push_back(row);
      r = make_load(12, 1, 1); r.sum = SUM_MIN; r.shift = 15;
      row = '{r, 1, '{18'sd0, SUM_MIN, 1'b0}}; directed.push_back(row);
      // integer lattice points give zero noise
      r = make_eval(0, 0, 0, 0, 15, 0);
      row = '{r, 1, '{18'sd0, 40'sd0, 1'b0}}; directed.push_back(row);
      r = make_eval(15, 48'sh7FFF_0000_0000, 48'sh8000_0000_0000, 48'sh0001_0000, 0, SUM_MAX);
      row = '{r, 1, '{18'sd0, SUM_MAX, 1'b0}}; directed.push_back(row);
      // predicted rows: coordinate extremes, saturation both ways, 2D slice
      directed.push_back('{make_eval(5, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
                                     48'sh7FFF_FFFF_FFFF, 0, 0), 0, none});
      directed.push_back('{make_eval(10, 48'sh8000_0000_0000, 48'sh8000_0000_0001,
                                     -48'sd1, 15, 0), 0, none});
      directed.push_back('{make_eval(15, -48'sd1, -48'sd1, -48'sd1, 7, 0), 0, none});
      directed.push_back('{make_eval(0, 48'sh8000, 48'sh8000, 48'sh8000, 3, 0), 0, none});
      directed.push_back('{make_eval(5, 48'sh1_4000, 0, 48'sh2_C000, 1, 0), 0, none});
      for (j = 0; j < 6; j++) begin
         directed.push_back('{make_eval(loaded_tables[j % 4], random_coord(), random_coord(),
                                        random_coord(), 15, SUM_MAX), 0, none});
         directed.push_back('{make_eval(loaded_tables[j % 4], random_coord(), random_coord(),
                                        random_coord(), 15, SUM_MIN), 0, none});
      end
      foreach (directed[n]) send_item(directed[n].req, directed[n].typed, directed[n].rsp);

      for (j = 0; j < RAND_ITEMS; j++) begin
         if (j == RAND_ITEMS / 3) begin
            sender_idle_pct = 65; receiver_stall_pct = 13;
         end else if (j == 2 * RAND_ITEMS / 3) begin
            sender_idle_pct = 0; receiver_stall_pct = 0;
         end
         if ($urandom_range(99) < 20) begin
            t = $urandom_range(15);
            send_item(make_load(t, $urandom_range(255), $urandom_range(255)), 0, none);
         end else begin
            // evaluate only on tables that are fully written
            do t = $urandom_range(15); while (!(&entry_written[t]));
            send_item(make_eval(t, random_coord(), ($urandom_range(9) == 0) ? '0 : random_coord(),
                                random_coord(), $urandom_range(15), random_sum()), 0, none);
         end
      end
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // outputs are stable by the falling edge; the transaction lands on the next rise
   always @(negedge clock) begin
      octave_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
         end else begin
            want = pending_results.pop_front();
            if (rsp_noise_value !== want.noise || rsp_sum_out !== want.sum ||
                rsp_saturated !== want.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch cycle %0d: noise %0d/%0d sum %0d/%0d sat %0b/%0b (exp/act)",
                           cycles, want.noise, rsp_noise_value, want.sum, rsp_sum_out,
                           want.sat, rsp_saturated);
            end
         end
      end
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/pn3oct_pkg.sv
rtl/perlin_noise_3d_octave_accumulate_core.sv
rtl/pn3oct_checker.sv
bench/testbench.sv
